FILE: design/dtsf_pkg.sv
`timescale 1ns / 1ps
package dtsf_pkg;

    // long divider widths, used by the front and back dividers: 33-bit numerator, 32-bit denominator
    localparam int DIV_NW = 33;
    localparam int DIV_DW = 32;

    // memory index field, wide enough for the largest supported image
    localparam int IDX_W = 20;

    localparam logic [2:0] CFG_DEPTH_TEST = 3'd0;
    localparam logic [2:0] CFG_SHADE      = 3'd1;
    localparam logic [2:0] CFG_RED        = 3'd2;
    localparam logic [2:0] CFG_GREEN      = 3'd3;
    localparam logic [2:0] CFG_BLUE       = 3'd4;
    localparam logic [2:0] CFG_COLUMNS    = 3'd5;

    localparam logic [1:0] SHADE_DEPTH = 2'd1;

    typedef struct packed {
        logic [7:0] base;
        logic       sgn;
        logic [7:0] qd;
        logic [7:0] rem;
    } t_chan8;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [15:0]      addr;
        logic [8:0]       cnt;
        logic             clip;
        logic [7:0]       n;
        logic [31:0]      inv_base;
        logic             inv_sgn;
        logic [31:0]      inv_qd;
        logic [7:0]       inv_rem;
        t_chan8 [2:0]     col;
    } t_span;

    typedef struct packed {
        logic       depth_test;
        logic [1:0] shade;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_cfg;

endpackage

FILE: design/dtsf_ram.sv
`timescale 1ns / 1ps
module dtsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

FILE: design/dtsf_div.sv
`timescale 1ns / 1ps
module dtsf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dtsf_pkg::DIV_NW-1:0] i_num,
    input  logic [dtsf_pkg::DIV_DW-1:0] i_den,
    output logic                       o_done,
    output logic [dtsf_pkg::DIV_NW-1:0] o_quo,
    output logic [dtsf_pkg::DIV_DW-1:0] o_rem
);
    import dtsf_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   n_trial;
    logic              n_bit;

    // one quotient bit a cycle, restoring
    always_comb begin
        n_trial = {r_rem, r_num[DIV_NW-1]};
        n_bit   = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[DIV_NW-2:0], 1'b0};
                r_quo <= {r_quo[DIV_NW-2:0], n_bit};
                if (n_bit) begin
                    r_rem <= DIV_DW'(n_trial - {1'b0, r_den});
                end else begin
                    r_rem <= n_trial[DIV_DW-1:0];
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

FILE: design/dtsf_fifo.sv
`timescale 1ns / 1ps
module dtsf_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dtsf_pkg::t_span i_data,
    output logic            o_full,
    input  logic            i_pop,
    output dtsf_pkg::t_span o_data,
    output logic            o_empty
);
    import dtsf_pkg::*;

    t_span      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
endmodule

FILE: design/dtsf_front.sv
`timescale 1ns / 1ps
module dtsf_front #(
    parameter int MAX_SPAN     = 64,
    parameter int IMAGE_PIXELS = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    output logic            o_busy,
    input  logic [7:0]      i_span_row,
    input  logic [7:0]      i_x_left,
    input  logic [7:0]      i_x_right,
    input  logic [15:0]     i_depth_left,
    input  logic [15:0]     i_depth_right,
    input  logic [7:0]      i_red_left,
    input  logic [7:0]      i_green_left,
    input  logic [7:0]      i_blue_left,
    input  logic [7:0]      i_red_right,
    input  logic [7:0]      i_green_right,
    input  logic [7:0]      i_blue_right,
    input  logic [8:0]      i_columns,
    output logic            o_push,
    output dtsf_pkg::t_span o_span,
    input  logic            i_full
);
    import dtsf_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_MOD  = 3'd2;
    localparam logic [2:0] F_DIV  = 3'd3;
    localparam logic [2:0] F_WAIT = 3'd4;
    localparam logic [2:0] F_PUSH = 3'd5;

    localparam logic [2:0] JOB_INV_L = 3'd0;
    localparam logic [2:0] JOB_INV_R = 3'd1;
    localparam logic [2:0] JOB_INV_D = 3'd2;
    localparam logic [2:0] JOB_COL_0 = 3'd3;
    localparam logic [2:0] JOB_COL_2 = 3'd5;

    localparam logic [20:0] IP21 = 21'(IMAGE_PIXELS);
    localparam logic [8:0]  MAX9 = 9'(MAX_SPAN);

    logic [2:0]  r_st;
    logic [2:0]  r_job;
    logic [7:0]  r_row;
    logic [7:0]  r_xa;
    logic [7:0]  r_n;
    logic [15:0] r_za;
    logic [15:0] r_zb;
    logic [7:0]  r_ca [3];
    logic [7:0]  r_cb [3];
    logic [31:0] r_inva;
    logic [31:0] r_invb;
    logic [17:0] r_addr;
    t_span       r_span;

    logic              n_swap;
    logic [17:0]       n_addr;
    logic [8:0]        n_cnt;
    logic [32:0]       n_dinv;
    logic [31:0]       n_ainv;
    logic [1:0]        n_k;
    logic [8:0]        n_dcol;
    logic [7:0]        n_acol;
    logic              n_start;
    logic [DIV_NW-1:0] n_num;
    logic [DIV_DW-1:0] n_den;
    logic              div_done;
    logic [DIV_NW-1:0] div_quo;
    logic [DIV_DW-1:0] div_rem;
    logic [31:0]       n_sat;

    always_comb begin
        n_swap = (i_x_left > i_x_right);
        n_addr = 18'(r_row) * 18'(i_columns) + 18'(r_xa);
        n_cnt  = 9'(r_n) + 9'd1;
        n_dinv = {1'b0, r_invb} - {1'b0, r_inva};
        n_ainv = n_dinv[32] ? 32'(-n_dinv) : n_dinv[31:0];
        n_k    = 2'(r_job - JOB_COL_0);
        n_dcol = {1'b0, r_cb[n_k]} - {1'b0, r_ca[n_k]};
        n_acol = n_dcol[8] ? 8'(-n_dcol) : n_dcol[7:0];
        n_sat  = div_quo[DIV_NW-1] ? 32'hFFFF_FFFF : div_quo[31:0];
        n_start = (r_st == F_DIV);
        case (r_job)
            JOB_INV_L: begin
                n_num = {1'b1, 32'd0};
                n_den = 32'(r_za);
            end
            JOB_INV_R: begin
                n_num = {1'b1, 32'd0};
                n_den = 32'(r_zb);
            end
            JOB_INV_D: begin
                n_num = {1'b0, n_ainv};
                n_den = 32'(r_n);
            end
            default: begin
                n_num = 33'(n_acol);
                n_den = 32'(r_n);
            end
        endcase
    end

    dtsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_start),
        .i_num   (n_num),
        .i_den   (n_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= F_IDLE;
            r_job <= JOB_INV_L;
        end else begin
            case (r_st)
                F_IDLE: begin
                    if (i_accept) begin
                        r_row <= i_span_row;
                        if (n_swap) begin
                            r_xa    <= i_x_right;
                            r_n     <= i_x_left - i_x_right;
                            r_za    <= i_depth_right;
                            r_zb    <= i_depth_left;
                            r_ca[0] <= i_red_right;
                            r_ca[1] <= i_green_right;
                            r_ca[2] <= i_blue_right;
                            r_cb[0] <= i_red_left;
                            r_cb[1] <= i_green_left;
                            r_cb[2] <= i_blue_left;
                        end else begin
                            r_xa    <= i_x_left;
                            r_n     <= i_x_right - i_x_left;
                            r_za    <= i_depth_left;
                            r_zb    <= i_depth_right;
                            r_ca[0] <= i_red_left;
                            r_ca[1] <= i_green_left;
                            r_ca[2] <= i_blue_left;
                            r_cb[0] <= i_red_right;
                            r_cb[1] <= i_green_right;
                            r_cb[2] <= i_blue_right;
                        end
                        r_st <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_addr        <= n_addr;
                    r_span.addr   <= n_addr[15:0];
                    r_span.n      <= r_n;
                    r_span.clip   <= (n_cnt > MAX9);
                    r_span.cnt    <= (n_cnt > MAX9) ? MAX9 : n_cnt;
                    r_st          <= F_MOD;
                end
                F_MOD: begin
                    // fold the address into the store, one subtraction a cycle
                    if ({3'd0, r_addr} >= IP21) begin
                        r_addr <= r_addr - IP21[17:0];
                    end else begin
                        r_span.idx <= IDX_W'(r_addr);
                        r_job      <= JOB_INV_L;
                        r_st       <= F_DIV;
                    end
                end
                F_DIV: begin
                    r_st <= F_WAIT;
                end
                F_WAIT: begin
                    if (div_done) begin
                        case (r_job)
                            JOB_INV_L: r_inva <= n_sat;
                            JOB_INV_R: r_invb <= n_sat;
                            JOB_INV_D: begin
                                r_span.inv_base <= r_inva;
                                r_span.inv_sgn  <= n_dinv[32];
                                r_span.inv_qd   <= div_quo[31:0];
                                r_span.inv_rem  <= div_rem[7:0];
                            end
                            default: begin
                                r_span.col[n_k].base <= r_ca[n_k];
                                r_span.col[n_k].sgn  <= n_dcol[8];
                                r_span.col[n_k].qd   <= div_quo[7:0];
                                r_span.col[n_k].rem  <= div_rem[7:0];
                            end
                        endcase
                        if (r_job == JOB_COL_2) begin
                            r_st <= F_PUSH;
                        end else begin
                            r_job <= r_job + 3'd1;
                            r_st  <= F_DIV;
                        end
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_st <= F_IDLE;
                    end
                end
                default: r_st <= F_IDLE;
            endcase
        end
    end

    assign o_busy = (r_st != F_IDLE);
    assign o_push = (r_st == F_PUSH) && !i_full;
    assign o_span = r_span;
endmodule

FILE: design/dtsf_back.sv
`timescale 1ns / 1ps
module dtsf_back #(
    parameter int IMAGE_PIXELS = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    output logic            o_pop,
    input  dtsf_pkg::t_span i_span,
    input  dtsf_pkg::t_cfg  i_cfg,
    output logic            o_clearing,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [15:0]     o_pixel_address,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue,
    output logic            o_write_pixel,
    output logic            o_span_last,
    output logic            o_span_clipped
);
    import dtsf_pkg::*;

    localparam int MIW = $clog2(IMAGE_PIXELS);
    localparam logic [MIW-1:0] IDX_LAST = MIW'(IMAGE_PIXELS - 1);

    localparam logic [2:0] B_CLR  = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_PIX  = 3'd2;
    localparam logic [2:0] B_CMP  = 3'd3;
    localparam logic [2:0] B_SHD  = 3'd4;
    localparam logic [2:0] B_OUT  = 3'd5;

    logic [2:0]     r_st;
    logic [MIW-1:0] r_clr;
    t_span          r_sp;
    logic [MIW-1:0] r_idx;
    logic [15:0]    r_addr;
    logic [8:0]     r_i;
    logic [31:0]    r_iq;
    logic [7:0]     r_ir;
    logic [7:0]     r_cq [3];
    logic [7:0]     r_cr [3];
    logic [15:0]    r_oaddr;
    logic [7:0]     r_oc [3];
    logic           r_ow;
    logic           r_ol;
    logic           r_ocl;

    logic [31:0]       n_invz;
    logic [7:0]        n_col [3];
    logic [8:0]        n_isum;
    logic [8:0]        n_csum [3];
    logic              n_last;
    logic              n_pass;
    logic              n_we;
    logic [MIW-1:0]    n_waddr;
    logic [31:0]       n_wdata;
    logic [31:0]       mem_q;
    logic              n_start;
    logic              div_done;
    logic [DIV_NW-1:0] div_quo;
    logic [DIV_DW-1:0] div_rem;
    logic [16:0]       n_d;
    logic [16:0]       n_m;
    logic [24:0]       n_prod [3];
    logic [7:0]        flat [3];

    always_comb begin
        flat[0] = i_cfg.red;
        flat[1] = i_cfg.green;
        flat[2] = i_cfg.blue;
        n_invz  = r_sp.inv_sgn ? r_sp.inv_base - r_iq : r_sp.inv_base + r_iq;
        n_isum  = {1'b0, r_ir} + {1'b0, r_sp.inv_rem};
        for (int k = 0; k < 3; k++) begin
            n_col[k]  = r_sp.col[k].sgn ? r_sp.col[k].base - r_cq[k]
                                        : r_sp.col[k].base + r_cq[k];
            n_csum[k] = {1'b0, r_cr[k]} + {1'b0, r_sp.col[k].rem};
        end
        n_last = (r_i == r_sp.cnt - 9'd1);
        n_pass = (n_invz > mem_q);
        n_start = (r_st == B_CMP) && n_pass && (i_cfg.shade == SHADE_DEPTH);

        // depth recovered from the inverse, capped at one
        if (n_invz <= 32'h0001_0000) begin
            n_d = 17'h1_0000;
        end else if (div_quo > 33'h0_0001_0000) begin
            n_d = 17'h1_0000;
        end else begin
            n_d = div_quo[16:0];
        end
        n_m = 17'h1_0000 - n_d;
        for (int k = 0; k < 3; k++) begin
            n_prod[k] = 25'(flat[k]) * 25'(n_m);
        end

        n_we    = 1'b0;
        n_waddr = r_idx;
        n_wdata = n_invz;
        if (r_st == B_CLR) begin
            n_we    = 1'b1;
            n_waddr = r_clr;
            n_wdata = '0;
        end else if (r_st == B_CMP && n_pass) begin
            n_we = 1'b1;
        end
    end

    dtsf_ram #(
        .WIDTH (32),
        .DEPTH (IMAGE_PIXELS)
    ) u_depth (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_q)
    );

    dtsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_start),
        .i_num   ({1'b1, 32'd0}),
        .i_den   (n_invz),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= B_CLR;
            r_clr <= '0;
        end else begin
            case (r_st)
                B_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IDX_LAST) begin
                        r_st <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        r_sp   <= i_span;
                        r_idx  <= i_span.idx[MIW-1:0];
                        r_addr <= i_span.addr;
                        r_i    <= '0;
                        r_iq   <= '0;
                        r_ir   <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_cq[k] <= '0;
                            r_cr[k] <= '0;
                        end
                        r_st <= B_PIX;
                    end
                end
                B_PIX: begin
                    r_oaddr <= r_addr;
                    r_ol    <= n_last;
                    r_ocl   <= n_last && r_sp.clip;
                    r_ow    <= 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        r_oc[k] <= n_col[k];
                    end
                    r_st <= i_cfg.depth_test ? B_CMP : B_OUT;
                end
                B_CMP: begin
                    if (!n_pass) begin
                        r_ow <= 1'b0;
                        for (int k = 0; k < 3; k++) begin
                            r_oc[k] <= '0;
                        end
                        r_st <= B_OUT;
                    end else if (i_cfg.shade == SHADE_DEPTH) begin
                        r_st <= B_SHD;
                    end else begin
                        r_st <= B_OUT;
                    end
                end
                B_SHD: begin
                    if (div_done) begin
                        for (int k = 0; k < 3; k++) begin
                            r_oc[k] <= n_prod[k][23:16];
                        end
                        r_st <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (!i_stall) begin
                        if (r_ol) begin
                            r_st <= B_IDLE;
                        end else begin
                            r_i    <= r_i + 9'd1;
                            r_addr <= r_addr + 16'd1;
                            r_idx  <= (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
                            if (n_isum >= {1'b0, r_sp.n}) begin
                                r_ir <= 8'(n_isum - {1'b0, r_sp.n});
                                r_iq <= r_iq + r_sp.inv_qd + 32'd1;
                            end else begin
                                r_ir <= n_isum[7:0];
                                r_iq <= r_iq + r_sp.inv_qd;
                            end
                            for (int k = 0; k < 3; k++) begin
                                if (n_csum[k] >= {1'b0, r_sp.n}) begin
                                    r_cr[k] <= 8'(n_csum[k] - {1'b0, r_sp.n});
                                    r_cq[k] <= r_cq[k] + r_sp.col[k].qd + 8'd1;
                                end else begin
                                    r_cr[k] <= n_csum[k][7:0];
                                    r_cq[k] <= r_cq[k] + r_sp.col[k].qd;
                                end
                            end
                            r_st <= B_PIX;
                        end
                    end
                end
                default: r_st <= B_IDLE;
            endcase
        end
    end

    assign o_pop           = (r_st == B_IDLE) && !i_empty;
    assign o_clearing      = (r_st == B_CLR);
    assign o_valid         = (r_st == B_OUT);
    assign o_pixel_address = r_oaddr;
    assign o_red           = r_oc[0];
    assign o_green         = r_oc[1];
    assign o_blue          = r_oc[2];
    assign o_write_pixel   = r_ow;
    assign o_span_last     = r_ol;
    assign o_span_clipped  = r_ocl;

    a_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_we |-> (r_st == B_CLR) || i_cfg.depth_test)
        else $error("depth store written with the depth test off");

    a_clip_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_span_clipped |-> o_span_last)
        else $error("clip flag away from the last pixel");

    a_fail_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_pixel |-> (o_red == 8'd0) && (o_green == 8'd0)
                                      && (o_blue == 8'd0))
        else $error("rejected pixel carries colour");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_st == B_PIX))
        else $error("span taken without starting its pixels");
endmodule

FILE: design/depth_tested_span_fill.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                  Moves
// in       input      i_in_valid / o_in_stall    one span item
// out      output     o_out_valid / i_out_stall  one pixel item
// cfg      input      i_cfg_valid / o_cfg_ready  one register write (index, data)
//
// Span setup in the front forms the row address, folds it into the depth store one
// subtraction at a time, then makes 6 divider passes (start, 33 quotient bits, done).
// Each pixel passes the PIX and OUT states, plus CMP with the depth test and, for a
// passing pixel under depth shading, SHD waiting on the per-pixel divider; the next
// span is set up while the current one is drawn.
// After reset a clearing pass writes zero over the depth store, during which o_in_stall
// stays high; register writes are taken throughout.
// A stalled output holds its item; the two-entry span queue lets the front run on.
module depth_tested_span_fill #(
    parameter int MAX_SPAN     = 64,
    parameter int IMAGE_PIXELS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_span_row,
    input  logic [7:0]  i_x_left,
    input  logic [7:0]  i_x_right,
    input  logic [15:0] i_depth_left,
    input  logic [15:0] i_depth_right,
    input  logic [7:0]  i_red_left,
    input  logic [7:0]  i_green_left,
    input  logic [7:0]  i_blue_left,
    input  logic [7:0]  i_red_right,
    input  logic [7:0]  i_green_right,
    input  logic [7:0]  i_blue_right,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_pixel_address,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic        o_write_pixel,
    output logic        o_span_last,
    output logic        o_span_clipped,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import dtsf_pkg::*;

    t_cfg       r_cfg;
    logic [8:0] r_columns;
    logic       front_busy;
    logic       clearing;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    t_span      span_in;
    t_span      span_out;

    // register file; writes are always taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= '0;
            r_columns <= 9'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEPTH_TEST: r_cfg.depth_test <= i_cfg_data[0];
                CFG_SHADE:      r_cfg.shade      <= i_cfg_data[1:0];
                CFG_RED:        r_cfg.red        <= i_cfg_data[7:0];
                CFG_GREEN:      r_cfg.green      <= i_cfg_data[7:0];
                CFG_BLUE:       r_cfg.blue       <= i_cfg_data[7:0];
                CFG_COLUMNS:    r_columns        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // hold off spans while setting one up or clearing the store
    assign o_in_stall = front_busy || clearing;

    dtsf_front #(
        .MAX_SPAN     (MAX_SPAN),
        .IMAGE_PIXELS (IMAGE_PIXELS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (i_in_valid && !o_in_stall),
        .o_busy        (front_busy),
        .i_span_row    (i_span_row),
        .i_x_left      (i_x_left),
        .i_x_right     (i_x_right),
        .i_depth_left  (i_depth_left),
        .i_depth_right (i_depth_right),
        .i_red_left    (i_red_left),
        .i_green_left  (i_green_left),
        .i_blue_left   (i_blue_left),
        .i_red_right   (i_red_right),
        .i_green_right (i_green_right),
        .i_blue_right  (i_blue_right),
        .i_columns     (r_columns),
        .o_push        (push),
        .o_span        (span_in),
        .i_full        (full)
    );

    dtsf_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (span_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (span_out),
        .o_empty (empty)
    );

    dtsf_back #(
        .IMAGE_PIXELS (IMAGE_PIXELS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .o_pop           (pop),
        .i_span          (span_out),
        .i_cfg           (r_cfg),
        .o_clearing      (clearing),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_pixel_address (o_pixel_address),
        .o_red           (o_out_red),
        .o_green         (o_out_green),
        .o_blue          (o_out_blue),
        .o_write_pixel   (o_write_pixel),
        .o_span_last     (o_span_last),
        .o_span_clipped  (o_span_clipped)
    );
endmodule
